>>> rtl/capture_period_frequency_meter_assert.svh
// Assertion macros shared by the frequency meter's RTL modules.
// Every macro samples on clock and is disabled while reset is high.
`ifndef CAPTURE_PERIOD_FREQUENCY_METER_ASSERT_SVH
`define CAPTURE_PERIOD_FREQUENCY_METER_ASSERT_SVH

// Condition holds at every sampled edge.
`define CPFM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CPFM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CPFM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/cpfm_pkg.sv
// Shared constants and controller/datapath interface types for the
// capture period frequency meter. No dependencies.
package cpfm_pkg;

   localparam int CAP_W             = 16;
   localparam int FREQ_W            = 32;
   localparam int AVG_COUNT_DEFAULT = 100;

   localparam logic [CAP_W-1:0]  WRAP_TOP       = 16'hFFFF;
   localparam logic [FREQ_W-1:0] CLOCK_HZ_RESET = 32'd168000000;

   // Response payload layout
   localparam int RSP_DATA_W = CAP_W + 2 * FREQ_W;
   localparam int RSP_USER_W = 2;

   typedef struct packed {
      logic store_first;   // latch first capture of a pair
      logic start_pair;    // latch period, load divider with clock_hz / period
      logic div_step;      // one restoring divider iteration
      logic finish_pair;   // take frequency, update window, maybe load the mean
      logic mean_step;     // one multiply-accumulate step of the window mean
      logic finish_avg;    // take window mean from the accumulator
      logic load_out;      // move result into the response register
   } cmd_type;

   typedef struct packed {
      logic pending;       // first capture held, waiting for the second
      logic steps_done;    // iteration count exhausted
      logic window_end;    // this pair completes the averaging window
      logic out_free;      // response register can take a new transaction
   } status_type;

endpackage

>>> rtl/capture_period_frequency_meter.sv
// Top level of the capture period frequency meter: sequencer plus datapath.
// Depends on cpfm_pkg, cpfm_ctrl and cpfm_dp.
//
//   channel | direction | payload
//   req_*   | in        | tdata[15:0] capture_value
//   rsp_*   | out       | tdata period_ticks, frequency, average_frequency;
//           |           | tuser zero_period, average_valid
//   csr_*   | in        | wdata[31:0] clock_hz, written when csr_we is high
//
// A first capture of a pair is stored. A second capture loads the divider,
// runs 32 radix-2 divider iterations, adds the frequency to the window and
// loads the response. The pair that closes a window adds the mean: three
// multiply-accumulate steps by the reciprocal of AVG_COUNT and one to take it.
// Synchronous reset; clock_hz returns to 168000000. A stalled response holds
// while first captures are still taken; the next pair waits after its divide.
module capture_period_frequency_meter #(
   parameter int AVG_COUNT = cpfm_pkg::AVG_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cpfm_pkg::FREQ_W-1:0]         csr_wdata,    // clock_hz
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cpfm_pkg::CAP_W-1:0]          req_tdata,    // capture_value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // period_ticks [15:0], frequency [47:16], average_frequency [79:48]
   output logic [cpfm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // zero_period [0], average_valid [1]
   output logic [cpfm_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   cpfm_pkg::cmd_type    cmd;
   cpfm_pkg::status_type sts;

   cpfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cpfm_dp #(
      .AVG_COUNT (AVG_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

>>> rtl/cpfm_ctrl.sv
// Sequencer for the frequency meter: accepts captures, runs the divide and
// mean passes and hands results to the response register. Uses cpfm_pkg.
`include "capture_period_frequency_meter_assert.svh"

module cpfm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  cpfm_pkg::status_type   sts,
   output cpfm_pkg::cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FDIV = 4'b0010,
      ST_MEAN = 4'b0100,
      ST_WAIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      fdiv_busy;
   logic      mean_busy;
   logic      quiet_state;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (sts.pending) begin
                  cmd.start_pair = 1'b1;
                  state_in       = ST_FDIV;
               end else begin
                  cmd.store_first = 1'b1;
               end
            end
         end
         ST_FDIV: begin
            if (!sts.steps_done) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.finish_pair = 1'b1;
               state_in        = sts.window_end ? ST_MEAN : ST_WAIT;
            end
         end
         ST_MEAN: begin
            if (!sts.steps_done) begin
               cmd.mean_step = 1'b1;
            end else begin
               cmd.finish_avg = 1'b1;
               state_in       = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // hold until the response register is free
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign fdiv_busy   = (state_ff == ST_FDIV) && !sts.steps_done;
   assign mean_busy   = (state_ff == ST_MEAN) && !sts.steps_done;
   assign quiet_state = (state_ff == ST_IDLE) || (state_ff == ST_WAIT);

   `CPFM_ASSERT_NEXT(a_start_runs_divider, cmd.start_pair, fdiv_busy, "divide not started")
   `CPFM_ASSERT_NEXT(a_window_mean, cmd.finish_pair && sts.window_end, mean_busy, "no mean pass")
   `CPFM_ASSERT_SAME(a_idle_divider_quiet, quiet_state, sts.steps_done, "busy outside a pass")

endmodule

>>> rtl/cpfm_dp.sv
// Datapath of the frequency meter: capture and period registers, restoring
// divider, reciprocal multiplier for the window mean, window accumulator and
// response register. Uses cpfm_pkg.
`include "capture_period_frequency_meter_assert.svh"

module cpfm_dp #(
   parameter int AVG_COUNT = cpfm_pkg::AVG_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cpfm_pkg::FREQ_W-1:0]         csr_wdata,
   input  logic [cpfm_pkg::CAP_W-1:0]          req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cpfm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [cpfm_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  cpfm_pkg::cmd_type                   cmd,
   output cpfm_pkg::status_type                sts
);

   localparam int CAP_W  = cpfm_pkg::CAP_W;
   localparam int FREQ_W = cpfm_pkg::FREQ_W;
   localparam int LOG_N  = $clog2(AVG_COUNT);
   localparam int SUM_W  = FREQ_W + LOG_N;
   localparam int CNT_W  = $clog2(AVG_COUNT + 1);
   localparam int DV_W   = CAP_W;
   localparam int STEP_W = $clog2(FREQ_W + 1);
   localparam int FREQ_SHIFT = SUM_W - FREQ_W;
   // floor(x / AVG_COUNT) equals (x * RECIP) >> RECIP_SHIFT for every x below 2**SUM_W;
   // the product is built 16 bits of RECIP per cycle, lowest digit first
   localparam int RECIP_SHIFT = SUM_W + LOG_N;
   localparam int MUL_STEPS   = (SUM_W + 1 + 15) / 16;
   localparam int RECIP_W     = 16 * MUL_STEPS;
   localparam int ACC_W       = SUM_W + 16;
   localparam int MEAN_SHIFT  = RECIP_SHIFT - 16 * (MUL_STEPS - 1);
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
   localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_FULL);
   localparam logic [CNT_W-1:0]   LAST_PAIR = CNT_W'(AVG_COUNT - 1);

   logic [FREQ_W-1:0] clock_ff, clock_in;
   logic              pending_ff, pending_in;
   logic [CAP_W-1:0]  first_ff, first_in;
   logic [CAP_W-1:0]  period_ff, period_in;
   logic              zero_ff, zero_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DV_W-1:0]   rem_ff, rem_in;
   logic [DV_W-1:0]   dvs_ff, dvs_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [RECIP_W-1:0] recip_ff, recip_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [FREQ_W-1:0] avg_ff, avg_in;
   logic              avg_valid_ff, avg_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [cpfm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [cpfm_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic [CAP_W-1:0]  period_calc;
   logic [FREQ_W-1:0] freq_calc;
   logic [SUM_W-1:0]  sum_next;
   logic [DV_W:0]     rem_shift;
   logic [DV_W:0]     rem_trial;
   logic              quo_bit;
   logic [ACC_W-1:0]  mul_part;
   logic              any_step;
   logic              window_close;
   logic              window_clear;

   // wrap-corrected distance between the stored and the incoming capture
   always_comb begin
      if (req_tdata < first_ff) begin
         period_calc = (cpfm_pkg::WRAP_TOP - first_ff) + req_tdata;
      end else begin
         period_calc = req_tdata - first_ff;
      end
   end

   assign freq_calc = zero_ff ? '0 : quo_ff[FREQ_W-1:0];
   assign sum_next  = sum_ff + SUM_W'(freq_calc);
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_trial = rem_shift - {1'b0, dvs_ff};
   assign quo_bit   = !rem_trial[DV_W];
   // window total times one 16-bit digit of the reciprocal
   assign mul_part  = ACC_W'(quo_ff) * ACC_W'(recip_ff[15:0]);

   always_comb begin
      clock_in     = csr_we ? csr_wdata : clock_ff;
      pending_in   = pending_ff;
      first_in     = first_ff;
      period_in    = period_ff;
      zero_in      = zero_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      steps_in     = steps_ff;
      acc_in       = acc_ff;
      recip_in     = recip_ff;
      freq_in      = freq_ff;
      avg_in       = avg_ff;
      avg_valid_in = avg_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (cmd.store_first) begin
         first_in   = req_tdata;
         pending_in = 1'b1;
      end

      if (cmd.start_pair) begin
         pending_in = 1'b0;
         period_in  = period_calc;
         zero_in    = (period_calc == '0);
         // numerator in the top bits so that the low FREQ_W bits end as quotient
         quo_in     = SUM_W'(clock_ff) << FREQ_SHIFT;
         rem_in     = '0;
         dvs_in     = DV_W'(period_calc);
         steps_in   = STEP_W'(FREQ_W);
      end

      if (cmd.div_step) begin
         rem_in   = quo_bit ? rem_trial[DV_W-1:0] : rem_shift[DV_W-1:0];
         quo_in   = {quo_ff[SUM_W-2:0], quo_bit};
         steps_in = steps_ff - 1'b1;
      end

      if (cmd.finish_pair) begin
         freq_in = freq_calc;
         if (sts.window_end) begin
            avg_valid_in = 1'b1;
            // hold the window total in the quotient register for the mean
            quo_in       = sum_next;
            acc_in       = '0;
            recip_in     = RECIP;
            steps_in     = STEP_W'(MUL_STEPS);
            sum_in       = '0;
            count_in     = '0;
         end else begin
            avg_valid_in = 1'b0;
            avg_in       = '0;
            sum_in       = sum_next;
            count_in     = count_ff + 1'b1;
         end
      end

      if (cmd.mean_step) begin
         // drop the finished low digit, add the next partial product
         acc_in   = (acc_ff >> 16) + mul_part;
         recip_in = recip_ff >> 16;
         steps_in = steps_ff - 1'b1;
      end

      if (cmd.finish_avg) begin
         avg_in = acc_ff[MEAN_SHIFT +: FREQ_W];
      end

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {avg_ff, freq_ff, period_ff};
         rsp_user_in  = {avg_valid_ff, zero_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff     <= cpfm_pkg::CLOCK_HZ_RESET;
         pending_ff   <= 1'b0;
         first_ff     <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clock_ff     <= clock_in;
         pending_ff   <= pending_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff    <= period_in;
      zero_ff      <= zero_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      acc_ff       <= acc_in;
      recip_ff     <= recip_in;
      freq_ff      <= freq_in;
      avg_ff       <= avg_in;
      avg_valid_ff <= avg_valid_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign sts.pending    = pending_ff;
   assign sts.steps_done = (steps_ff == '0);
   assign sts.window_end = (count_ff == LAST_PAIR);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign any_step     = cmd.div_step || cmd.mean_step;
   assign window_close = cmd.finish_pair && sts.window_end;
   assign window_clear = (sum_ff == '0) && (count_ff == '0);

   `CPFM_ASSERT_ALWAYS(a_count_in_window, count_ff <= LAST_PAIR, "pair count beyond window")
   `CPFM_ASSERT_SAME(a_step_needs_count, any_step, steps_ff != '0, "step count exhausted")
   `CPFM_ASSERT_NEXT(a_window_clears_sum, window_close, window_clear, "window state not cleared")

endmodule

>>> bench/capture_period_frequency_meter_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the capture period frequency meter. It follows clock_hz writes and
// accepted captures, predicts every pair's measurement and checks the responses.
// Depends on cpfm_pkg.
module capture_period_frequency_meter_checker #(
   parameter int AVG_COUNT = cpfm_pkg::AVG_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cpfm_pkg::FREQ_W-1:0]     csr_wdata,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [cpfm_pkg::CAP_W-1:0]      req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [cpfm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [cpfm_pkg::RSP_USER_W-1:0] rsp_tuser,
   output int                              error_count,
   output int                              awaited_count
);
   import cpfm_pkg::*;

   typedef struct {
      logic [CAP_W-1:0]  period_ticks;
      logic [FREQ_W-1:0] frequency;
      logic              zero_period;
      logic              average_valid;
      logic [FREQ_W-1:0] average_frequency;
   } measurement_t;

   measurement_t      awaited_measurements[$];
   logic [FREQ_W-1:0] clock_hz;
   logic              holding_first;
   logic [CAP_W-1:0]  first_capture;
   int unsigned       pairs_in_window;
   logic [63:0]       window_sum;
   int                errors = 0;

   function automatic void measure_capture(input logic [CAP_W-1:0] capture);
      measurement_t m;
      if (!holding_first) begin
         first_capture = capture;
         holding_first = 1'b1;
         return;
      end
      holding_first = 1'b0;
      if (capture > first_capture)
         m.period_ticks = capture - first_capture;
      else if (capture < first_capture)
         m.period_ticks = (WRAP_TOP - first_capture) + capture;
      else
         m.period_ticks = '0;
      // a zero period (equal captures, or top then zero) skips the divide
      m.zero_period = (m.period_ticks == '0);
      if (m.zero_period)
         m.frequency = '0;
      else
         m.frequency = clock_hz / FREQ_W'(m.period_ticks);
      window_sum += 64'(m.frequency);
      pairs_in_window++;
      m.average_valid = 1'b0;
      m.average_frequency = '0;
      if (pairs_in_window >= AVG_COUNT) begin
         m.average_frequency = FREQ_W'(window_sum / 64'(AVG_COUNT));
         m.average_valid = 1'b1;
         window_sum = '0;
         pairs_in_window = 0;
      end
      awaited_measurements.push_back(m);
   endfunction

   function automatic void compare_field(input string name, input logic [FREQ_W-1:0] expected,
                                         input logic [FREQ_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s: expected 'h%0h, actual 'h%0h", name, expected, actual);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      measurement_t m;
      if (reset) begin
         clock_hz = CLOCK_HZ_RESET;
         holding_first = 1'b0;
         first_capture = '0;
         pairs_in_window = 0;
         window_sum = '0;
         awaited_measurements.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_measurements.size() == 0) begin
               $error("response transaction with no measurement awaited");
               errors++;
            end else begin
               m = awaited_measurements.pop_front();
               compare_field("period_ticks", FREQ_W'(m.period_ticks), FREQ_W'(rsp_tdata[15:0]));
               compare_field("frequency", m.frequency, rsp_tdata[47:16]);
               compare_field("average_frequency", m.average_frequency, rsp_tdata[79:48]);
               compare_field("zero_period", FREQ_W'(m.zero_period), FREQ_W'(rsp_tuser[0]));
               compare_field("average_valid", FREQ_W'(m.average_valid), FREQ_W'(rsp_tuser[1]));
            end
         end
         if (req_tvalid && req_tready)
            measure_capture(req_tdata);
         if (csr_we)
            clock_hz = csr_wdata;
      end
      error_count <= errors;
      awaited_count <= awaited_measurements.size();
   end

endmodule

>>> bench/capture_period_frequency_meter_test.sv
`timescale 1ns / 1ps
// Top of the frequency meter bench: clock, reset, capture stimulus and clock_hz writes.
// Depends on cpfm_pkg, capture_period_frequency_meter and its checker module.
module capture_period_frequency_meter_test;
   import cpfm_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 80;
   localparam int SEGMENT_ITEMS = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [FREQ_W-1:0]     csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CAP_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   int                    error_count;
   int                    awaited_count;
   int                    cycle_count = 0;
   int                    items_sent = 0;
   bit                    steady = 1'b0;

   capture_period_frequency_meter #(
      .AVG_COUNT (AVG_COUNT_DEFAULT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   capture_period_frequency_meter_checker #(
      .AVG_COUNT (AVG_COUNT_DEFAULT)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .awaited_count (awaited_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 33);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("capture_period_frequency_meter_test failed");
         $finish;
      end
   end

   // Keep valid high across back-to-back transactions; drop it only for a gap.
   task automatic send_capture(input logic [CAP_W-1:0] capture);
      if (!steady && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (!steady && $urandom_range(0, 99) < 33);
      end
      req_tvalid <= 1'b1;
      req_tdata <= capture;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_pair(input logic [CAP_W-1:0] lead, input logic [CAP_W-1:0] trail);
      send_capture(lead);
      send_capture(trail);
   endtask

   task automatic send_random_pair();
      logic [CAP_W-1:0] lead;
      logic [CAP_W-1:0] trail;
      int               shape;
      // a lone capture now and then shifts the pairing
      if ($urandom_range(0, 99) < 4)
         send_capture(CAP_W'($urandom_range(0, 65535)));
      lead = CAP_W'($urandom_range(0, 65535));
      shape = $urandom_range(0, 99);
      if (shape < 45)
         trail = lead + CAP_W'($urandom_range(1, 64));
      else if (shape < 85)
         trail = CAP_W'($urandom_range(0, 65535));
      else if (shape < 92)
         trail = lead;
      else
         trail = lead - CAP_W'($urandom_range(0, 2));
      send_pair(lead, trail);
   endtask

   // Hold the sender until every measurement is in and the divider has settled.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_clock_hz(input logic [FREQ_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset clock_hz: shortest and longest periods, wraps, equal captures
      send_pair(16'h0000, 16'h0001);
      send_pair(16'h0001, 16'h0000);
      send_pair(16'h0000, 16'hFFFF);
      send_pair(16'h0007, 16'h0007);
      send_pair(16'hFFFF, 16'h0000);
      send_pair(16'hFFFF, 16'hFFFF);
      send_pair(16'h8000, 16'h7FFF);
      send_pair(16'h1234, 16'hABCD);

      wait_idle();
      write_clock_hz(32'hFFFF_FFFF);
      send_pair(16'h0000, 16'h0001);
      send_pair(16'hAAAA, 16'h5555);

      wait_idle();
      write_clock_hz(32'd0);
      send_pair(16'h0003, 16'h0009);

      for (int segment = 0; segment < 6; segment++) begin
         wait_idle();
         case (segment)
            0: write_clock_hz($urandom);
            1: write_clock_hz(32'hFFFF_FFFF);
            2: write_clock_hz(32'd0);
            3: write_clock_hz(32'd1);
            4: write_clock_hz($urandom_range(2, 100000));
            default: write_clock_hz(CLOCK_HZ_RESET);
         endcase
         steady = (segment == 2);
         while (items_sent < 22 + SEGMENT_ITEMS * (segment + 1))
            send_random_pair();
      end
      steady = 1'b0;

      wait_idle();
      if (error_count == 0)
         $display("capture_period_frequency_meter_test passed");
      else
         $display("capture_period_frequency_meter_test failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/cpfm_pkg.sv
rtl/cpfm_ctrl.sv
rtl/cpfm_dp.sv
rtl/capture_period_frequency_meter.sv
bench/capture_period_frequency_meter_checker.sv
bench/capture_period_frequency_meter_test.sv
